// File: rtl/core/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants of the LCG random draw unit: draw op codes,
// controller states, datapath command and status words.
// ----------------------------------------------------------------------------
package lrd_pkg;

	localparam int WEIGHT_ENTRIES = 8;
	localparam int WEIGHT_BITS    = 16;
	localparam int IDX_W          = $clog2(WEIGHT_ENTRIES);
	localparam int N_W            = $clog2(WEIGHT_ENTRIES + 1);
	localparam int CMP_W          = N_W + IDX_W;
	localparam int TOTAL_W        = WEIGHT_BITS + $clog2(WEIGHT_ENTRIES);

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [15:0] SCALE16 = 16'hFFFF;
	localparam logic [23:0] SCALE24 = 24'hFFFFFF;

	// u (24b) times 33b signed operand
	localparam int PROD_W    = 57;
	localparam int QUO_W     = 34;
	localparam int S_TDATA_W = 168;

	typedef enum logic [3:0] {
		OP_SEED     = 4'd0,
		OP_UNIT     = 4'd1,
		OP_FINE     = 4'd2,
		OP_BETWEEN  = 4'd3,
		OP_FBETWEEN = 4'd4,
		OP_CHANCE   = 4'd5,
		OP_SIGN     = 4'd6,
		OP_SIGNED   = 4'd7,
		OP_BELOW    = 4'd8,
		OP_LOADW    = 4'd9,
		OP_WEIGHTED = 4'd10
	} lrd_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DRAW,
		S_MULHI,
		S_ABS,
		S_DIV,
		S_FIX,
		S_SUM,
		S_TOTAL,
		S_SCAN,
		S_OUT
	} lrd_state_t;

	typedef enum logic [1:0] {
		MUL_SPAN,
		MUL_COUNT,
		MUL_TOTAL
	} lrd_mul_sel_t;

	typedef enum logic [3:0] {
		RES_UNIT,
		RES_FINE,
		RES_CHANCE,
		RES_SIGN,
		RES_SIGNED,
		RES_BETWEEN,
		RES_BELOW,
		RES_ZERO,
		RES_EMPTY,
		RES_MISS,
		RES_HIT
	} lrd_res_sel_t;

	typedef struct packed {
		logic         capture;
		logic         seed;
		logic         wr_weight;
		logic         advance;
		logic         fine;
		lrd_mul_sel_t mul_sel;
		logic         mul_lo;
		logic         mul_hi;
		logic         div_init;
		logic         div_step;
		logic         res_load;
		lrd_res_sel_t res_sel;
		logic         sum_clr;
		logic         sum_acc;
		logic         scan_init;
		logic         scan_step;
		logic         idx_inc;
		logic         load_out;
	} lrd_cmd_t;

	typedef struct packed {
		logic count_pos;
		logic total_zero;
		logic div_done;
		logic scan_hit;
		logic idx_last;
	} lrd_status_t;

endpackage

// File: rtl/core/lcg_random_draw_unit_top.sv
// ----------------------------------------------------------------------------
// lcg_random_draw_unit_top
// Random draw unit on a 32-bit LCG: uniform, ranged, chance, sign and
// weighted index draws, with an 8-entry weight table.
// ----------------------------------------------------------------------------
// Usage:
//  One command word enters on the s_ channel (command in s_tuser, operands
//  in s_tdata). Seed and load-weight update state and return no word; codes
//  above weighted are dropped. Every other command returns one word on the
//  m_ channel: value in m_tdata, flag in m_tuser.
//  Commands are handled one at a time. Unit/fine/chance/sign/signed draw
//  and return; below with count <= 0 returns zero without a draw;
//  between/fine-between/below take two multiplier passes, then the
//  fold-and-add divider by 2^k-1; weighted sums the table, returns when
//  empty, else draws, divides and scans up to 8 entries one per cycle.
//  Seed and load-weight keep the unit busy only while they update state;
//  otherwise the next word is taken once the result is in the output register.
//  s_tready is high whenever no command is in progress, also while an
//  output word is still waiting; a command that finishes while the output
//  word is stalled waits until it is taken. Reset clears the generator
//  state and the weight table and empties the output.
// ----------------------------------------------------------------------------
module lcg_random_draw_unit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, from bit 0: seed_value[32], low_bound[32], high_bound[32],
	// probability[16], draw_count[32], weight_index[3], weight_value[16], pad[5]
	input  logic [lrd_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: command[4]
	input  logic [3:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: result_value[32]
	output logic [31:0]                   m_tdata,
	// m_tuser: result_flag[1]
	output logic [0:0]                    m_tuser
);

	lrd_pkg::lrd_cmd_t    cmd;
	lrd_pkg::lrd_status_t status;
	logic                 out_flag;

	lrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.out_value (m_tdata),
		.out_flag  (out_flag)
	);

	assign m_tuser = out_flag;

endmodule

// File: rtl/core/lrd_dpath.sv
// ----------------------------------------------------------------------------
// lrd_dpath
// Datapath: generator state, weight table, two-pass multiplier, divider by
// 2^k-1 (fold and add), weight sum and scan, result and output registers.
// ----------------------------------------------------------------------------
module lrd_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lrd_pkg::lrd_cmd_t              cmd,
	output lrd_pkg::lrd_status_t           status,
	input  logic [lrd_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic [31:0]                    out_value,
	output logic                           out_flag
);

	logic [31:0]        seed_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic [15:0]        prob_q;
	logic signed [31:0] count_q;
	logic [2:0]         widx_q;
	logic [15:0]        wval_q;
	logic [lrd_pkg::N_W-1:0] n_q;
	logic signed [31:0] cnt_in;

	logic [31:0] lcg_q;
	logic [lrd_pkg::WEIGHT_BITS-1:0] weight_q [lrd_pkg::WEIGHT_ENTRIES];

	logic [15:0] u16;
	logic [23:0] u24;
	logic [23:0] mul_a;
	logic [32:0] span;
	logic [32:0] mul_b;
	logic [39:0] prod_lo;
	logic signed [41:0] prod_hi;
	logic [lrd_pkg::PROD_W-1:0] prod_q;

	logic                       neg_q;
	logic [lrd_pkg::PROD_W-1:0] r_q;
	logic [lrd_pkg::QUO_W-1:0]  q_q;
	logic [lrd_pkg::PROD_W-1:0] r_hi;
	logic [lrd_pkg::PROD_W-1:0] r_lo;
	logic [lrd_pkg::PROD_W-1:0] div_d;
	logic                       r_full;
	logic                       r_nz;
	logic [lrd_pkg::QUO_W-1:0]  q_fin;
	logic [lrd_pkg::QUO_W:0]    mag;
	logic [lrd_pkg::QUO_W:0]    quo;
	logic [lrd_pkg::QUO_W:0]    between_w;
	logic [31:0]                below_v;

	logic [lrd_pkg::TOTAL_W-1:0]     total_q;
	logic [lrd_pkg::TOTAL_W-1:0]     run_q;
	logic [lrd_pkg::TOTAL_W-1:0]     roll_q;
	logic [lrd_pkg::IDX_W-1:0]       idx_q;
	logic [lrd_pkg::WEIGHT_BITS-1:0] w_cur;
	logic                            in_rng;
	logic [lrd_pkg::TOTAL_W-1:0]     run_next;

	logic [31:0] res_val_q;
	logic        res_flag_q;
	logic [31:0] out_value_q;
	logic        out_flag_q;

	// input word capture
	assign cnt_in = s_tdata[143:112];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seed_q  <= s_tdata[31:0];
			lo_q    <= s_tdata[63:32];
			hi_q    <= s_tdata[95:64];
			prob_q  <= s_tdata[111:96];
			count_q <= cnt_in;
			widx_q  <= s_tdata[146:144];
			wval_q  <= s_tdata[162:147];
			if (cnt_in[31] || cnt_in == 32'sd0) begin
				n_q <= '0;
			end else if (cnt_in > 32'(lrd_pkg::WEIGHT_ENTRIES)) begin
				n_q <= lrd_pkg::N_W'(lrd_pkg::WEIGHT_ENTRIES);
			end else begin
				n_q <= cnt_in[lrd_pkg::N_W-1:0];
			end
		end
	end

	// generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= '0;
		end else if (cmd.seed) begin
			lcg_q <= seed_q;
		end else if (cmd.advance) begin
			lcg_q <= lcg_q * lrd_pkg::LCG_MUL + lrd_pkg::LCG_ADD;
		end
	end

	// weight table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrd_pkg::WEIGHT_ENTRIES; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cmd.wr_weight &&
				(lrd_pkg::CMP_W'(widx_q) < lrd_pkg::CMP_W'(lrd_pkg::WEIGHT_ENTRIES))) begin
			weight_q[widx_q[lrd_pkg::IDX_W-1:0]] <= wval_q[lrd_pkg::WEIGHT_BITS-1:0];
		end
	end

	// multiplier, low half then signed high half of the operand
	assign u16   = lcg_q[23:8];
	assign u24   = lcg_q[31:8];
	assign mul_a = cmd.fine ? u24 : {8'h00, u16};
	assign span  = {hi_q[31], hi_q} - {lo_q[31], lo_q};

	always_comb begin
		case (cmd.mul_sel)
			lrd_pkg::MUL_SPAN:  mul_b = span;
			lrd_pkg::MUL_COUNT: mul_b = {count_q[31], count_q};
			lrd_pkg::MUL_TOTAL: mul_b = 33'(total_q);
			default:            mul_b = '0;
		endcase
	end

	assign prod_lo = 40'(mul_a) * 40'(mul_b[15:0]);
	assign prod_hi = $signed({18'h00000, mul_a}) * $signed({{25{mul_b[32]}}, mul_b[32:16]});

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_q <= lrd_pkg::PROD_W'(prod_lo);
		end else if (cmd.mul_hi) begin
			prod_q <= prod_q + {prod_hi[40:0], 16'h0000};
		end
	end

	// divide by 2^k-1: n = a*2^k + b  ->  q += a, r = a + b
	assign r_hi  = cmd.fine ? (r_q >> 24) : (r_q >> 16);
	assign r_lo  = cmd.fine ? (r_q & lrd_pkg::PROD_W'(lrd_pkg::SCALE24))
	                        : (r_q & lrd_pkg::PROD_W'(lrd_pkg::SCALE16));
	assign div_d = cmd.fine ? lrd_pkg::PROD_W'(lrd_pkg::SCALE24)
	                        : lrd_pkg::PROD_W'(lrd_pkg::SCALE16);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= prod_q[lrd_pkg::PROD_W-1];
			r_q   <= prod_q[lrd_pkg::PROD_W-1] ? (lrd_pkg::PROD_W'(0) - prod_q) : prod_q;
			q_q   <= '0;
		end else if (cmd.div_step) begin
			q_q <= q_q + r_hi[lrd_pkg::QUO_W-1:0];
			r_q <= r_hi + r_lo;
		end
	end

	assign r_full    = (r_q == div_d);
	assign r_nz      = (r_q != '0) && !r_full;
	assign q_fin     = q_q + lrd_pkg::QUO_W'(r_full);
	assign mag       = {1'b0, q_fin} + (lrd_pkg::QUO_W + 1)'(r_nz);
	assign quo       = neg_q ? ((lrd_pkg::QUO_W + 1)'(0) - mag) : {1'b0, q_fin};
	assign between_w = {{(lrd_pkg::QUO_W - 31){lo_q[31]}}, lo_q} + quo;
	assign below_v   = (q_fin >= lrd_pkg::QUO_W'(unsigned'(count_q))) ?
	                   (count_q - 32'sd1) : q_fin[31:0];

	// weight sum and scan
	assign w_cur    = weight_q[idx_q];
	assign in_rng   = lrd_pkg::CMP_W'(idx_q) < lrd_pkg::CMP_W'(n_q);
	assign run_next = run_q + lrd_pkg::TOTAL_W'(w_cur);

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			total_q <= '0;
		end else if (cmd.sum_acc && in_rng) begin
			total_q <= total_q + lrd_pkg::TOTAL_W'(w_cur);
		end
		if (cmd.scan_init) begin
			roll_q <= q_fin[lrd_pkg::TOTAL_W-1:0];
			run_q  <= '0;
		end else if (cmd.scan_step) begin
			run_q <= run_next;
		end
		if (cmd.sum_clr || cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// result
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_flag_q <= 1'b0;
			case (cmd.res_sel)
				lrd_pkg::RES_UNIT:    res_val_q <= {16'h0000, u16};
				lrd_pkg::RES_FINE:    res_val_q <= {8'h00, u24};
				lrd_pkg::RES_CHANCE: begin
					res_val_q  <= {16'h0000, u16};
					res_flag_q <= (u16 < prob_q);
				end
				lrd_pkg::RES_SIGN:    res_val_q <= u16[15] ? 32'h0000_0001 : 32'hFFFF_FFFF;
				lrd_pkg::RES_SIGNED:  res_val_q <= {15'h0000, u16, 1'b0} - 32'(lrd_pkg::SCALE16);
				lrd_pkg::RES_BETWEEN: res_val_q <= between_w[31:0];
				lrd_pkg::RES_BELOW:   res_val_q <= below_v;
				lrd_pkg::RES_EMPTY: begin
					res_val_q  <= 32'hFFFF_FFFF;
					res_flag_q <= 1'b1;
				end
				lrd_pkg::RES_MISS:    res_val_q <= 32'hFFFF_FFFF;
				lrd_pkg::RES_HIT:     res_val_q <= 32'(idx_q);
				default:              res_val_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= res_val_q;
			out_flag_q  <= res_flag_q;
		end
	end

	assign out_value = out_value_q;
	assign out_flag  = out_flag_q;

	assign status.count_pos  = !count_q[31] && (count_q != 32'sd0);
	assign status.total_zero = (total_q == '0);
	assign status.div_done   = (r_hi == '0);
	assign status.scan_hit   = in_rng && (w_cur != '0) && (run_next >= roll_q);
	assign status.idx_last   = (idx_q == lrd_pkg::IDX_W'(lrd_pkg::WEIGHT_ENTRIES - 1));

endmodule

// File: rtl/core/lrd_ctrl.sv
// ----------------------------------------------------------------------------
// lrd_ctrl
// Controller: sequences one command at a time through the datapath and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module lrd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [3:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  lrd_pkg::lrd_status_t status,
	output lrd_pkg::lrd_cmd_t    cmd
);

	lrd_pkg::lrd_state_t state_q;
	lrd_pkg::lrd_state_t state_d;
	lrd_pkg::lrd_op_t    op_q;
	logic                m_valid_q;
	logic                simple_op;

	assign s_tready = (state_q == lrd_pkg::S_IDLE);
	assign m_tvalid = m_valid_q;

	assign simple_op = (op_q == lrd_pkg::OP_UNIT) || (op_q == lrd_pkg::OP_FINE) ||
	                   (op_q == lrd_pkg::OP_CHANCE) || (op_q == lrd_pkg::OP_SIGN) ||
	                   (op_q == lrd_pkg::OP_SIGNED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lrd_pkg::S_IDLE;
			op_q      <= lrd_pkg::OP_SEED;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) begin
				op_q <= lrd_pkg::lrd_op_t'(s_tuser);
			end
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrd_pkg::S_IDLE: begin
				if (s_tvalid) state_d = lrd_pkg::S_DECODE;
			end
			lrd_pkg::S_DECODE: begin
				unique case (op_q) inside
					lrd_pkg::OP_UNIT, lrd_pkg::OP_FINE, lrd_pkg::OP_BETWEEN,
					lrd_pkg::OP_FBETWEEN, lrd_pkg::OP_CHANCE, lrd_pkg::OP_SIGN,
					lrd_pkg::OP_SIGNED: state_d = lrd_pkg::S_DRAW;
					lrd_pkg::OP_BELOW: begin
						state_d = status.count_pos ? lrd_pkg::S_DRAW : lrd_pkg::S_OUT;
					end
					lrd_pkg::OP_WEIGHTED: state_d = lrd_pkg::S_SUM;
					default:              state_d = lrd_pkg::S_IDLE;
				endcase
			end
			lrd_pkg::S_DRAW:  state_d = simple_op ? lrd_pkg::S_OUT : lrd_pkg::S_MULHI;
			lrd_pkg::S_MULHI: state_d = lrd_pkg::S_ABS;
			lrd_pkg::S_ABS:   state_d = lrd_pkg::S_DIV;
			lrd_pkg::S_DIV: begin
				if (status.div_done) state_d = lrd_pkg::S_FIX;
			end
			lrd_pkg::S_FIX: begin
				state_d = (op_q == lrd_pkg::OP_WEIGHTED) ? lrd_pkg::S_SCAN : lrd_pkg::S_OUT;
			end
			lrd_pkg::S_SUM: begin
				if (status.idx_last) state_d = lrd_pkg::S_TOTAL;
			end
			lrd_pkg::S_TOTAL: begin
				state_d = status.total_zero ? lrd_pkg::S_OUT : lrd_pkg::S_DRAW;
			end
			lrd_pkg::S_SCAN: begin
				if (status.scan_hit || status.idx_last) state_d = lrd_pkg::S_OUT;
			end
			lrd_pkg::S_OUT: begin
				if (!m_valid_q || m_tready) state_d = lrd_pkg::S_IDLE;
			end
			default: state_d = lrd_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.fine    = (op_q == lrd_pkg::OP_FINE) || (op_q == lrd_pkg::OP_FBETWEEN);
		cmd.mul_sel = lrd_pkg::MUL_SPAN;
		cmd.res_sel = lrd_pkg::RES_ZERO;
		if (op_q == lrd_pkg::OP_BELOW) cmd.mul_sel = lrd_pkg::MUL_COUNT;
		if (op_q == lrd_pkg::OP_WEIGHTED) cmd.mul_sel = lrd_pkg::MUL_TOTAL;
		unique case (state_q)
			lrd_pkg::S_IDLE: cmd.capture = s_tvalid;
			lrd_pkg::S_DECODE: begin
				unique case (op_q) inside
					lrd_pkg::OP_SEED:  cmd.seed = 1'b1;
					lrd_pkg::OP_LOADW: cmd.wr_weight = 1'b1;
					lrd_pkg::OP_UNIT, lrd_pkg::OP_FINE, lrd_pkg::OP_BETWEEN,
					lrd_pkg::OP_FBETWEEN, lrd_pkg::OP_CHANCE, lrd_pkg::OP_SIGN,
					lrd_pkg::OP_SIGNED: cmd.advance = 1'b1;
					lrd_pkg::OP_BELOW: begin
						cmd.advance  = status.count_pos;
						cmd.res_load = !status.count_pos;
						cmd.res_sel  = lrd_pkg::RES_ZERO;
					end
					lrd_pkg::OP_WEIGHTED: cmd.sum_clr = 1'b1;
					default: ;
				endcase
			end
			lrd_pkg::S_DRAW: begin
				if (simple_op) begin
					cmd.res_load = 1'b1;
					unique case (op_q) inside
						lrd_pkg::OP_FINE:   cmd.res_sel = lrd_pkg::RES_FINE;
						lrd_pkg::OP_CHANCE: cmd.res_sel = lrd_pkg::RES_CHANCE;
						lrd_pkg::OP_SIGN:   cmd.res_sel = lrd_pkg::RES_SIGN;
						lrd_pkg::OP_SIGNED: cmd.res_sel = lrd_pkg::RES_SIGNED;
						default:            cmd.res_sel = lrd_pkg::RES_UNIT;
					endcase
				end else begin
					cmd.mul_lo = 1'b1;
				end
			end
			lrd_pkg::S_MULHI: cmd.mul_hi = 1'b1;
			lrd_pkg::S_ABS:   cmd.div_init = 1'b1;
			lrd_pkg::S_DIV:   cmd.div_step = !status.div_done;
			lrd_pkg::S_FIX: begin
				unique case (op_q) inside
					lrd_pkg::OP_WEIGHTED: cmd.scan_init = 1'b1;
					lrd_pkg::OP_BELOW: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = lrd_pkg::RES_BELOW;
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = lrd_pkg::RES_BETWEEN;
					end
				endcase
			end
			lrd_pkg::S_SUM: begin
				cmd.sum_acc = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			lrd_pkg::S_TOTAL: begin
				cmd.advance  = !status.total_zero;
				cmd.res_load = status.total_zero;
				cmd.res_sel  = lrd_pkg::RES_EMPTY;
			end
			lrd_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (status.scan_hit) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = lrd_pkg::RES_HIT;
				end else if (status.idx_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = lrd_pkg::RES_MISS;
				end
			end
			lrd_pkg::S_OUT: cmd.load_out = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_valid_q || m_tready))
		else $error("output word overwritten before taken");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == lrd_pkg::S_DECODE))
		else $error("accepted word not decoded");

	a_state_writes: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.seed, cmd.advance, cmd.wr_weight}))
		else $error("conflicting state updates");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lrd_pkg::S_IDLE) |-> !s_tready)
		else $error("ready while busy");

endmodule
